@@ hw/rtl/ile_pkg.sv @@
// Shared types and constants for the indexed list engine.
// Used by ile_cell and indexed_list_engine_top; depends on nothing else.
package ile_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W   = 4;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT    = 4'd0,
    OP_ADD_BACK     = 4'd1,
    OP_INSERT_AT    = 4'd2,
    OP_REMOVE_FRONT = 4'd3,
    OP_REMOVE_BACK  = 4'd4,
    OP_REMOVE_AT    = 4'd5,
    OP_READ_FRONT   = 4'd6,
    OP_READ_BACK    = 4'd7,
    OP_READ_AT      = 4'd8,
    OP_REPLACE_AT   = 4'd9
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // What every cell does at the commit edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     commit;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

endpackage

@@ hw/rtl/ile_cell.sv @@
// One storage cell of the list chain: holds one entry and one stage of the read-out line.
// Depends on ile_pkg.
module ile_cell
  import ile_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int IDX_W      = 6,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [IDX_W-1:0]      target,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] left_entry,
  input  logic [DATA_WIDTH-1:0] right_entry,
  input  logic [DATA_WIDTH-1:0] rd_in,
  output logic [DATA_WIDTH-1:0] entry,
  output logic [DATA_WIDTH-1:0] rd_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                  hit;
  logic                  above;
  logic [DATA_WIDTH-1:0] entry_next;

  assign hit   = (target == MY_IDX);
  assign above = (MY_IDX > target);

  always_comb begin
    entry_next = entry;
    if (cmd.commit) begin
      case (cmd.op)
        CELL_INSERT: begin
          if (above) entry_next = left_entry;
          else if (hit) entry_next = wdata;
        end
        CELL_REMOVE: begin
          if (above || hit) entry_next = right_entry;
        end
        CELL_WRITE: begin
          if (hit) entry_next = wdata;
        end
        default: entry_next = entry;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    // The addressed cell keeps loading its entry; every other cell passes its
    // upper neighbor's word down toward cell zero.
    rd_out <= hit ? entry : rd_in;
  end

endmodule

@@ hw/rtl/indexed_list_engine_top.sv @@
// Top level of the indexed list engine: request decode, control and the chain of cells.
// Depends on ile_pkg and ile_cell.
//
// A request is taken when start is high and busy is low; its result appears on
// value_out, count and status for exactly one cycle with done high, and the
// receiver cannot hold it off. Adds, errors and unused codes go straight to
// the commit state, then the result is registered; the block may take a new
// word in the result cycle. Reads, removes and replaces fetch the addressed
// entry through the cell chain's read-out line toward cell zero, one cell per
// cycle, and wait in the scan state until entry t (t is the position: 0 for
// front, count - 1 for back) reaches cell zero, then commit. Inserts and
// removes shift all later cells at once. Entries need no clearing after reset.
module indexed_list_engine_top
  import ile_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation,
  input  logic [POS_W-1:0]  position,
  input  logic [VAL_W-1:0]  value_in,
  output logic              done,
  output logic [VAL_W-1:0]  value_out,
  output logic [CNT_W-1:0]  count,
  output logic [STAT_W-1:0] status
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int EW    = (CW > POS_W) ? CW : POS_W;
  localparam int OW    = (EW > CNT_W) ? EW : CNT_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t state, state_next;

  logic [CW-1:0]         stored_count;
  logic [CW-1:0]         stored_count_next;
  logic [IDX_W-1:0]      target;
  logic [IDX_W-1:0]      scan_cnt;
  logic [DATA_WIDTH-1:0] wdata;
  cell_op_t              pend_op;
  logic                  pend_read;
  status_t               pend_status;

  // Decode of the incoming request.
  cell_op_t          dec_op;
  logic              dec_read;
  status_t           dec_status;
  logic [IDX_W-1:0]  dec_target;
  logic              full;
  logic              empty;
  logic [EW-1:0]     pos_ext;
  logic [EW-1:0]     cnt_ext;
  logic              accept;
  logic [DATA_WIDTH+VAL_W-1:0] vin_ext;

  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] entry  [CAPACITY];
  logic [DATA_WIDTH-1:0] rd     [CAPACITY];
  logic [DATA_WIDTH-1:0] left_w [CAPACITY];
  logic [DATA_WIDTH-1:0] right_w[CAPACITY];
  logic [DATA_WIDTH-1:0] rdin_w [CAPACITY];
  logic [DATA_WIDTH+VAL_W-1:0] rd0_ext;
  logic [OW-1:0]         count_wide;

  assign accept  = start && !busy;
  assign full    = (stored_count == CAP_C);
  assign empty   = (stored_count == '0);
  assign pos_ext = EW'(position);
  assign cnt_ext = EW'(stored_count);
  assign vin_ext = {{DATA_WIDTH{1'b0}}, value_in};

  always_comb begin
    dec_op     = CELL_HOLD;
    dec_read   = 1'b0;
    dec_status = ST_OK;
    dec_target = '0;
    unique case (operation) inside
      OP_ADD_FRONT: begin
        if (full) dec_status = ST_FULL;
        else dec_op = CELL_INSERT;
      end
      OP_ADD_BACK: begin
        dec_target = IDX_W'(stored_count);
        if (full) dec_status = ST_FULL;
        else dec_op = CELL_INSERT;
      end
      OP_INSERT_AT: begin
        dec_target = IDX_W'(position);
        if (pos_ext > cnt_ext) dec_status = ST_RANGE;
        else if (full) dec_status = ST_FULL;
        else dec_op = CELL_INSERT;
      end
      OP_REMOVE_FRONT, OP_READ_FRONT: begin
        if (empty) dec_status = ST_EMPTY;
        else begin
          dec_read = 1'b1;
          if (operation == OP_REMOVE_FRONT) dec_op = CELL_REMOVE;
        end
      end
      OP_REMOVE_BACK, OP_READ_BACK: begin
        dec_target = IDX_W'(stored_count - CW'(1));
        if (empty) dec_status = ST_EMPTY;
        else begin
          dec_read = 1'b1;
          if (operation == OP_REMOVE_BACK) dec_op = CELL_REMOVE;
        end
      end
      OP_REMOVE_AT, OP_READ_AT, OP_REPLACE_AT: begin
        dec_target = IDX_W'(position);
        if (pos_ext >= cnt_ext) dec_status = ST_RANGE;
        else begin
          dec_read = 1'b1;
          if (operation == OP_REMOVE_AT) dec_op = CELL_REMOVE;
          else if (operation == OP_REPLACE_AT) dec_op = CELL_WRITE;
        end
      end
      default: begin
        dec_op = CELL_HOLD;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = dec_read ? S_SCAN : S_COMMIT;
      S_SCAN:   if (scan_cnt == target) state_next = S_COMMIT;
      S_COMMIT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs toward the cells and the handshake.
  always_comb begin
    busy       = 1'b1;
    cmd.op     = pend_op;
    cmd.commit = 1'b0;
    unique case (state)
      S_IDLE:   busy = 1'b0;
      S_SCAN:   busy = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_comb begin
    stored_count_next = stored_count;
    if (cmd.commit) begin
      if (pend_op == CELL_INSERT) stored_count_next = stored_count + CW'(1);
      else if (pend_op == CELL_REMOVE) stored_count_next = stored_count - CW'(1);
    end
  end

  assign rd0_ext = {{VAL_W{1'b0}}, rd[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stored_count <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      stored_count <= stored_count_next;
      done         <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      target      <= dec_target;
      wdata       <= vin_ext[DATA_WIDTH-1:0];
      pend_op     <= dec_op;
      pend_read   <= dec_read;
      pend_status <= dec_status;
    end
    if (state == S_SCAN) scan_cnt <= scan_cnt + IDX_W'(1);
    else scan_cnt <= '0;
    if (cmd.commit) begin
      value_out  <= pend_read ? rd0_ext[VAL_W-1:0] : '0;
      count_wide <= OW'(stored_count_next);
      status     <= pend_status;
    end
  end

  assign count = count_wide[CNT_W-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_mid_l
      assign left_w[i] = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i] = '0;
      assign rdin_w[i]  = '0;
    end else begin : g_mid_r
      assign right_w[i] = entry[i+1];
      assign rdin_w[i]  = rd[i+1];
    end

    ile_cell #(
      .INDEX      (i),
      .IDX_W      (IDX_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .target      (target),
      .wdata       (wdata),
      .left_entry  (left_w[i]),
      .right_entry (right_w[i]),
      .rd_in       (rdin_w[i]),
      .entry       (entry[i]),
      .rd_out      (rd[i])
    );
  end

  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_COMMIT))
    else $error("result word without a commit cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CAP_C)
    else $error("stored count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (stored_count == CAP_C))
    else $error("full status while list has room");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after taking a word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_COMMIT) |=> $stable(stored_count))
    else $error("count changed outside a commit cycle");

endmodule
